FILE: rtl/b64v_pkg.sv
package b64v_pkg;

    // one symbol in the queue: pad mark on top, base64 sextet below
    localparam int SYM_W      = 7;
    localparam int MAX_CHARS  = 4;
    localparam int QDEPTH     = 2;
    localparam int KEY_SYMS   = 16;
    localparam int KEY_W      = 6;
    localparam int CFG_W      = 48;
    localparam int CFG_IDX_W  = 2;
    localparam int LEN_W      = 5;

    localparam logic [SYM_W-1:0] SYM_PAD = 7'h40;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 2'd2;

    localparam logic [5:0] SEXTET_PLUS  = 6'd62;
    localparam logic [5:0] SEXTET_SLASH = 6'd63;
    localparam logic [KEY_W-1:0] KEY_NONE = 6'd63;
    localparam logic [6:0] VIG_MOD = 7'd63;

    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_PAD   = 8'h3D;

    typedef logic [SYM_W-1:0] t_sym;

    typedef struct packed {
        logic [2:0]                 count;
        logic [MAX_CHARS-1:0][SYM_W-1:0] sym;
        logic                       last;
    } t_entry;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_push;

    typedef logic [KEY_SYMS-1:0][KEY_W-1:0] t_keys;

    // base64 letter/digit sextet (0..61) to its place in the cipher alphabet
    function automatic logic [5:0] b64_to_vig(input logic [5:0] s);
        logic [5:0] r;
        if (s < 6'd26) begin
            r = s + 6'd26;
        end else if (s < 6'd52) begin
            r = s - 6'd26;
        end else begin
            r = s;
        end
        return r;
    endfunction

    // cipher alphabet: a-z, A-Z, 0-9, space
    function automatic logic [7:0] vig_char(input logic [5:0] i);
        logic [7:0] c;
        if (i < 6'd26) begin
            c = 8'h61 + {2'b00, i};
        end else if (i < 6'd52) begin
            c = 8'h41 + {2'b00, i - 6'd26};
        end else if (i < 6'd62) begin
            c = 8'h30 + {2'b00, i - 6'd52};
        end else begin
            c = 8'h20;
        end
        return c;
    endfunction

endpackage

FILE: rtl/b64v_front.sv
module b64v_front import b64v_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic        i_full,
    output t_push       o_push
);

    localparam logic [2:0] LC_0 = 3'd0;
    localparam logic [2:0] LC_2 = 3'd2;
    localparam logic [2:0] LC_4 = 3'd4;

    logic [3:0] r_left_bits, n_left_bits;
    logic [2:0] r_left_cnt,  n_left_cnt;
    logic [1:0] r_cmf,       n_cmf;

    logic       accept;
    logic [2:0] n_chars;
    logic [2:0] total;
    logic [1:0] cmf_sum;
    logic [1:0] pads;
    logic [5:0] flush;
    t_entry     e;

    assign accept = i_valid && !i_full;

    always_comb begin
        e           = '0;
        n_chars     = 3'd1;
        n_left_bits = 4'd0;
        n_left_cnt  = LC_0;
        flush       = 6'd0;
        case (r_left_cnt)
            LC_0: begin
                e.sym[0]    = {1'b0, i_data_byte[7:2]};
                n_left_bits = {2'b00, i_data_byte[1:0]};
                n_left_cnt  = LC_2;
                flush       = {i_data_byte[1:0], 4'b0000};
            end
            LC_2: begin
                e.sym[0]    = {1'b0, r_left_bits[1:0], i_data_byte[7:4]};
                n_left_bits = i_data_byte[3:0];
                n_left_cnt  = LC_4;
                flush       = {i_data_byte[3:0], 2'b00};
            end
            default: begin
                e.sym[0]    = {1'b0, r_left_bits, i_data_byte[7:6]};
                e.sym[1]    = {1'b0, i_data_byte[5:0]};
                n_chars     = 3'd2;
            end
        endcase

        if (i_last_byte && n_left_cnt != LC_0) begin
            e.sym[n_chars[1:0]] = {1'b0, flush};
            n_chars = n_chars + 3'd1;
        end

        cmf_sum = r_cmf + n_chars[1:0];
        pads    = 2'd0 - cmf_sum;
        total   = n_chars;
        if (i_last_byte) begin
            total = n_chars + {1'b0, pads};
            if (total > 3'(MAX_CHARS)) begin
                total = 3'(MAX_CHARS);
            end
            for (int j = 0; j < MAX_CHARS; j++) begin
                if (3'(j) >= n_chars && 3'(j) < total) begin
                    e.sym[j] = SYM_PAD;
                end
            end
        end
        e.count = total;
        e.last  = i_last_byte;

        n_cmf = cmf_sum;
        if (i_last_byte) begin
            n_left_bits = 4'd0;
            n_left_cnt  = LC_0;
            n_cmf       = 2'd0;
        end
    end

    assign o_push.valid = accept;
    assign o_push.entry = e;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_bits <= 4'd0;
            r_left_cnt  <= LC_0;
            r_cmf       <= 2'd0;
        end else if (accept) begin
            r_left_bits <= n_left_bits;
            r_left_cnt  <= n_left_cnt;
            r_cmf       <= n_cmf;
        end
    end

endmodule

FILE: rtl/b64v_fifo.sv
module b64v_fifo import b64v_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_push  i_push,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_valid,
    output t_entry o_head
);

    localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CW = $clog2(QDEPTH + 1);

    t_entry         r_mem [QDEPTH];
    logic [AW-1:0]  r_wr, r_rd;
    logic [CW-1:0]  r_cnt;
    logic           do_pop;

    assign o_full  = (r_cnt == CW'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr] <= i_push.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr <= (r_wr == AW'(QDEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(QDEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            case ({i_push.valid, do_pop})
                2'b10:   r_cnt <= r_cnt + CW'(1);
                2'b01:   r_cnt <= r_cnt - CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

FILE: rtl/b64v_back.sv
module b64v_back import b64v_pkg::*; #(
    parameter int MAX_KEY_LEN = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_head_valid,
    input  t_entry               i_head,
    output logic                 o_pop,
    input  logic                 i_stall,
    output logic                 o_valid,
    output logic [7:0]           o_out_char,
    output logic                 o_last_char
);

    localparam int KPW = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;
    localparam logic [LEN_W-1:0] MAXL = LEN_W'(MAX_KEY_LEN);

    logic [LEN_W-1:0] r_key_len;
    logic [CFG_W-1:0] r_key_low, r_key_high;
    logic [KPW-1:0]   r_key_pos;
    logic [1:0]       r_idx;
    logic             r_valid;
    logic [7:0]       r_char;
    logic             r_last;

    t_keys            keys;
    logic [LEN_W-1:0] eff_len, kp_ext, pos, pos_inc, pos_next;
    logic [KEY_W-1:0] key;
    t_sym             sym;
    logic [6:0]       sum;
    logic [6:0]       wrapped;
    logic [7:0]       n_char;
    logic             at_end;
    logic             load;

    assign keys = {r_key_high, r_key_low};

    always_comb begin
        eff_len = r_key_len;
        if (eff_len == '0) begin
            eff_len = LEN_W'(1);
        end else if (eff_len > MAXL) begin
            eff_len = MAXL;
        end
        kp_ext   = LEN_W'(r_key_pos);
        pos      = (kp_ext < eff_len) ? kp_ext : '0;
        pos_inc  = pos + LEN_W'(1);
        pos_next = (pos_inc >= eff_len) ? '0 : pos_inc;
        key      = keys[pos[3:0]];
        if (key == KEY_NONE) begin
            key = '0;
        end
    end

    // letters and digits get the key shift, everything else passes
    always_comb begin
        sym     = i_head.sym[r_idx];
        sum     = {1'b0, b64_to_vig(sym[5:0])} + {1'b0, key};
        wrapped = (sum >= VIG_MOD) ? sum - VIG_MOD : sum;
        if (sym == SYM_PAD) begin
            n_char = CHAR_PAD;
        end else if (sym[5:0] == SEXTET_PLUS) begin
            n_char = CHAR_PLUS;
        end else if (sym[5:0] == SEXTET_SLASH) begin
            n_char = CHAR_SLASH;
        end else begin
            n_char = vig_char(wrapped[5:0]);
        end
    end

    assign load   = i_head_valid && (!r_valid || !i_stall);
    assign at_end = ({1'b0, r_idx} == i_head.count - 3'd1);
    assign o_pop  = load && at_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_len  <= LEN_W'(1);
            r_key_low  <= '0;
            r_key_high <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_KEY_LEN:  r_key_len  <= i_cfg_data[LEN_W-1:0];
                CFG_KEY_LOW:  r_key_low  <= i_cfg_data;
                CFG_KEY_HIGH: r_key_high <= i_cfg_data;
                default:      r_key_len  <= r_key_len;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_pos <= '0;
            r_idx     <= '0;
            r_valid   <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                if (at_end) begin
                    r_idx <= '0;
                end else begin
                    r_idx <= r_idx + 2'd1;
                end
                if (at_end && i_head.last) begin
                    r_key_pos <= '0;
                end else begin
                    r_key_pos <= pos_next[KPW-1:0];
                end
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_char <= n_char;
            r_last <= at_end && i_head.last;
        end
    end

    assign o_valid     = r_valid;
    assign o_out_char  = r_char;
    assign o_last_char = r_last;

endmodule

FILE: rtl/base64_vigenere_encrypt.sv
// base64_vigenere_encrypt
// Input channel: one message byte per transfer (i_valid / o_stall), with
// i_last_byte marking the final byte. Output channel: one encrypted base64
// character per transfer (o_valid / i_stall), o_last_char on the final one.
// A byte makes 1 or 2 characters, the last byte up to 4 including '=' pad.
// A byte's characters enter the queue as one entry and then pass one by one
// through the output register of the cipher stage. The output emits one
// character per cycle while i_stall is low and the queue holds a byte, and a
// byte holds the cipher stage until all its characters are loaded, so the
// single-character output register sets the steady byte rate.
// A two-entry queue sits between the byte classifier and the cipher stage, so
// the input keeps taking bytes while the receiver stalls until the queue
// fills; o_stall then rises. A stalled output character holds.
// Key registers are written through i_cfg_we / i_cfg_index / i_cfg_data
// by the user only while no message is in flight, unchecked by the block:
// 0 key length, 1 key symbols 0-7, 2 key symbols 8-15 (six bits each,
// symbol i in bits 6i+5..6i). Synchronous reset empties the queue, clears
// encoder and key position, and sets key length 1 with all key symbols zero.
module base64_vigenere_encrypt import b64v_pkg::*; #(
    parameter int MAX_KEY_LEN = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_last_byte,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [7:0]           o_out_char,
    output logic                 o_last_char
);

    t_push  push;
    t_entry head;
    logic   full;
    logic   head_valid;
    logic   pop;

    assign o_stall = full;

    b64v_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_full      (full),
        .o_push      (push)
    );

    b64v_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (head_valid),
        .o_head  (head)
    );

    b64v_back #(
        .MAX_KEY_LEN (MAX_KEY_LEN)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_out_char   (o_out_char),
        .o_last_char  (o_last_char)
    );

endmodule

FILE: rtl/b64v_checker.sv
module b64v_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_out_char,
    input logic       o_last_char
);

    default clocking cb @(posedge i_clk); endclocking

    // reset empties the queue and the output register
    a_out_idle_after_reset: assert property (!i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    a_in_ready_after_reset: assert property (!i_rst_n |=> !o_stall)
        else $error("input stalled right after reset");

    // every character is from the cipher alphabet or one of + / =
    a_char_legal: assert property (disable iff (!i_rst_n)
        o_valid |-> ((o_out_char >= 8'h61 && o_out_char <= 8'h7A) ||
                     (o_out_char >= 8'h41 && o_out_char <= 8'h5A) ||
                     (o_out_char >= 8'h30 && o_out_char <= 8'h39) ||
                     o_out_char == 8'h20 || o_out_char == 8'h2B ||
                     o_out_char == 8'h2F || o_out_char == 8'h3D))
        else $error("illegal output character");

    a_out_hold: assert property (disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_char) && $stable(o_last_char))
        else $error("stalled output changed");

endmodule

bind base64_vigenere_encrypt b64v_checker u_b64v_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_out_char  (o_out_char),
    .o_last_char (o_last_char)
);
